>>> src/segment_tree_sum_engine_top_assert.svh
// Assertion macros for the segment tree sum engine.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef SEGMENT_TREE_SUM_ENGINE_TOP_ASSERT_SVH
`define SEGMENT_TREE_SUM_ENGINE_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define STSUM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define STSUM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/stsum_pkg.sv
// Shared constants for the segment tree sum engine: field widths,
// opcodes and status codes. No dependencies.
`default_nettype none

package stsum_pkg;

  localparam int unsigned PosW   = 10;
  localparam int unsigned ValW   = 64;
  localparam int unsigned StatW  = 2;

  localparam logic OP_SET   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [StatW-1:0] STATUS_OK       = 2'd0;
  localparam logic [StatW-1:0] STATUS_BAD_POS  = 2'd1;
  localparam logic [StatW-1:0] STATUS_REVERSED = 2'd2;

endpackage

`default_nettype wire

>>> src/segment_tree_sum_engine_top.sv
// Segment tree sum engine: point update and range sum over a heap-ordered
// tree held in one synchronous RAM. Depends on stsum_pkg and the assertion
// macro header segment_tree_sum_engine_top_assert.svh.
//
//  Channel | Handshake               | Payload
//  --------+-------------------------+----------------------------------------------
//  in      | in_valid_i / in_stall_o | opcode_i, first_position_i, last_position_i,
//          |                         | new_value_i
//  out     | out_valid_o/ out_stall_i| range_total_o, status_o
//
// A set does one RAM read-modify-write per tree level, from the leaf up to the root.
// A query steps the left and right ends up the tree; the single RAM read port is
// used at most once for the left end and at most once for the right end per level.
// A bad position or reversed range goes straight to the done state without the RAM.
// After reset the RAM is swept to zero, one entry per cycle, over all
// 2^TREE_LEVELS entries; requests are stalled during the sweep.
// A finished result waits in the output register while the next request runs.
`default_nettype none

`include "segment_tree_sum_engine_top_assert.svh"

module segment_tree_sum_engine_top
  import stsum_pkg::*;
#(
  parameter int unsigned TREE_LEVELS = 10
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic             opcode_i,
  input  wire logic [PosW-1:0]  first_position_i,
  input  wire logic [PosW-1:0]  last_position_i,
  input  wire logic [ValW-1:0]  new_value_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [ValW-1:0]       range_total_o,
  output logic [StatW-1:0]      status_o
);

  localparam int unsigned NodeW     = TREE_LEVELS;
  localparam int unsigned NodeCount = 1 << TREE_LEVELS;
  localparam int unsigned LeafCount = 1 << (TREE_LEVELS - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SET_DIFF,
    ST_SET_UP,
    ST_Q_LO,
    ST_Q_HI,
    ST_Q_DRAIN,
    ST_DONE
  } state_e;

  state_e            state_q, state_d;
  logic              clr_busy_q;
  logic [NodeW-1:0]  clr_idx_q;
  logic              pend_q, pend_d;
  logic              out_valid_q;
  logic [ValW-1:0]   range_total_q;
  logic [StatW-1:0]  status_q;

  logic [NodeW-1:0]  node_q, node_d;
  logic [NodeW:0]    lo_q, lo_d;
  logic [NodeW-1:0]  hi_q, hi_d;
  logic [NodeW-1:0]  hi_dec;
  logic [ValW-1:0]   diff_q, diff_d;
  logic [ValW-1:0]   acc_q, acc_d;
  logic [ValW-1:0]   value_q, value_d;
  logic [ValW-1:0]   res_total_q, res_total_d;
  logic [StatW-1:0]  res_status_q, res_status_d;

  // Tree RAM, one read and one write port, registered read data.
  logic [ValW-1:0]   mem [NodeCount];
  logic              rd_en, wr_en;
  logic [NodeW-1:0]  rd_addr, wr_addr;
  logic [ValW-1:0]   wr_data;
  logic [ValW-1:0]   rdata_q;

  logic              in_accept;
  logic              out_load;
  logic              first_ok, last_ok;
  logic [NodeW-1:0]  leaf_first, leaf_last;

  assign in_stall_o = clr_busy_q || (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;

  assign first_ok = (first_position_i != '0) && (32'(first_position_i) <= LeafCount);
  assign last_ok  = (last_position_i != '0) && (32'(last_position_i) <= LeafCount);

  // Valid positions always fit the node index width, so truncation is harmless.
  assign leaf_first = NodeW'(LeafCount) + NodeW'(first_position_i) - NodeW'(1);
  assign leaf_last  = NodeW'(LeafCount) + NodeW'(last_position_i) - NodeW'(1);

  assign out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d      = state_q;
    node_d       = node_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    hi_dec       = hi_q;
    diff_d       = diff_q;
    acc_d        = acc_q;
    value_d      = value_q;
    res_total_d  = res_total_q;
    res_status_d = res_status_q;
    pend_d       = 1'b0;
    rd_en        = 1'b0;
    rd_addr      = '0;
    wr_en        = 1'b0;
    wr_addr      = '0;
    wr_data      = '0;

    // A read issued by the query walk lands in the next cycle.
    if (pend_q) begin
      acc_d = acc_q + rdata_q;
    end

    if (clr_busy_q) begin
      wr_en   = 1'b1;
      wr_addr = clr_idx_q;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          acc_d        = '0;
          res_total_d  = '0;
          res_status_d = STATUS_OK;
          if (opcode_i == OP_SET) begin
            if (!first_ok) begin
              res_status_d = STATUS_BAD_POS;
              state_d      = ST_DONE;
            end else begin
              rd_en   = 1'b1;
              rd_addr = leaf_first;
              node_d  = leaf_first;
              value_d = new_value_i;
              state_d = ST_SET_DIFF;
            end
          end else begin
            if (!first_ok || !last_ok) begin
              res_status_d = STATUS_BAD_POS;
              state_d      = ST_DONE;
            end else if (first_position_i > last_position_i) begin
              res_status_d = STATUS_REVERSED;
              state_d      = ST_DONE;
            end else begin
              lo_d    = {1'b0, leaf_first};
              hi_d    = leaf_last;
              state_d = ST_Q_LO;
            end
          end
        end
      end
      ST_SET_DIFF: begin
        // The leaf takes the new value; ancestors take the difference.
        diff_d  = value_q - rdata_q;
        wr_en   = 1'b1;
        wr_addr = node_q;
        wr_data = value_q;
        rd_en   = 1'b1;
        rd_addr = node_q >> 1;
        node_d  = node_q >> 1;
        state_d = ST_SET_UP;
      end
      ST_SET_UP: begin
        wr_en   = 1'b1;
        wr_addr = node_q;
        wr_data = rdata_q + diff_q;
        if (node_q == NodeW'(1)) begin
          state_d = ST_DONE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = node_q >> 1;
          node_d  = node_q >> 1;
        end
      end
      ST_Q_LO: begin
        if (lo_q <= {1'b0, hi_q}) begin
          if (lo_q[0]) begin
            rd_en   = 1'b1;
            rd_addr = lo_q[NodeW-1:0];
            pend_d  = 1'b1;
            lo_d    = lo_q + 1'b1;
          end
          state_d = ST_Q_HI;
        end else begin
          state_d = ST_Q_DRAIN;
        end
      end
      ST_Q_HI: begin
        if (!hi_q[0]) begin
          rd_en   = 1'b1;
          rd_addr = hi_q;
          pend_d  = 1'b1;
          hi_dec  = hi_q - 1'b1;
        end
        lo_d    = lo_q >> 1;
        hi_d    = hi_dec >> 1;
        state_d = ST_Q_LO;
      end
      ST_Q_DRAIN: begin
        res_total_d = acc_d;
        state_d     = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    node_q       <= node_d;
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    diff_q       <= diff_d;
    acc_q        <= acc_d;
    value_q      <= value_d;
    res_total_q  <= res_total_d;
    res_status_q <= res_status_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      clr_busy_q    <= 1'b1;
      clr_idx_q     <= '0;
      pend_q        <= 1'b0;
      out_valid_q   <= 1'b0;
      range_total_q <= '0;
      status_q      <= STATUS_OK;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      if (clr_busy_q) begin
        clr_idx_q <= clr_idx_q + 1'b1;
        if (clr_idx_q == '1) begin
          clr_busy_q <= 1'b0;
        end
      end
      if (out_load) begin
        out_valid_q   <= 1'b1;
        range_total_q <= res_total_q;
        status_q      <= res_status_q;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign range_total_o = range_total_q;
  assign status_o      = status_q;

  `STSUM_ASSERT_SAME(a_accept_only_idle, in_valid_i && !in_stall_o,
                     state_q == ST_IDLE && !clr_busy_q, "request accepted while busy")
  `STSUM_ASSERT_SAME(a_err_zero_total, out_valid_o && status_o != STATUS_OK,
                     range_total_o == '0, "error result carries a nonzero sum")
  `STSUM_ASSERT_SAME(a_query_no_write,
                     state_q == ST_Q_LO || state_q == ST_Q_HI || state_q == ST_Q_DRAIN,
                     !wr_en, "tree written during a query")
  `STSUM_ASSERT_SAME(a_set_node_valid, state_q == ST_SET_UP, node_q != '0,
                     "update walked past the root")
  `STSUM_ASSERT_NEXT(a_load_sets_valid, out_load, out_valid_o,
                     "finished result not presented")

endmodule

`default_nettype wire
